### rtl/core/ierp_pkg.sv
package ierp_pkg;

  localparam logic [15:0] MAX_DATAGRAM    = 16'hFFFF;
  localparam logic [15:0] IP_MIN_LEN      = 16'd20;
  localparam logic [6:0]  ICMP_HDR_LEN    = 7'd8;
  localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;
  localparam logic [7:0]  ECHO_REPLY_CODE = 8'd0;

  // Byte offsets within the ICMP header.
  localparam logic [2:0] OFF_TYPE    = 3'd0;
  localparam logic [2:0] OFF_CODE    = 3'd1;
  localparam logic [2:0] OFF_CSUM_HI = 3'd2;
  localparam logic [2:0] OFF_CSUM_LO = 3'd3;
  localparam logic [2:0] OFF_IDENT_HI = 3'd4;
  localparam logic [2:0] OFF_IDENT_LO = 3'd5;
  localparam logic [2:0] OFF_SEQ_HI   = 3'd6;
  localparam logic [2:0] OFF_SEQ_LO   = 3'd7;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED   = 2'd0,
    STATUS_SHORT_IP   = 2'd1,
    STATUS_SHORT_ICMP = 2'd2,
    STATUS_NOT_ECHO   = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [5:0]  header_bytes;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] ident;
    logic [15:0] seq;
  } parse_state_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    status_e     status;
    logic [15:0] reply_id;
    logic [15:0] reply_sequence;
  } result_t;

endpackage

### rtl/core/ierp_step.sv
module ierp_step import ierp_pkg::*; (
  input  parse_state_t cur_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  output parse_state_t nxt_o,
  output result_t      res_o,
  output logic         res_valid_o
);

  logic [15:0]  pos;
  logic         saturated;
  logic         first;
  logic [5:0]   hdr;
  logic [6:0]   hdr_end;
  logic [2:0]   pos_rel;
  logic         in_window;
  logic         echo;
  logic         pay;
  logic [15:0]  len;
  status_e      status;
  parse_state_t cap;

  always_comb begin
    pos       = cur_i.byte_count;
    saturated = pos >= MAX_DATAGRAM;
    first     = pos == 16'd0;
    hdr       = first ? {data_byte_i[3:0], 2'b00} : cur_i.header_bytes;
    hdr_end   = {1'b0, hdr} + ICMP_HDR_LEN;
    pos_rel   = pos[2:0] - hdr[2:0];
    in_window = !saturated && (pos >= {10'd0, hdr}) && (pos < {9'd0, hdr_end});

    // A new datagram starts with all captured ICMP fields cleared.
    cap = cur_i;
    if (first) begin
      cap.icmp_type = '0;
      cap.icmp_code = '0;
      cap.ident     = '0;
      cap.seq       = '0;
    end
    cap.header_bytes = hdr;

    if (in_window) begin
      unique case (pos_rel)
        OFF_TYPE:     cap.icmp_type   = data_byte_i;
        OFF_CODE:     cap.icmp_code   = data_byte_i;
        OFF_CSUM_HI:  ;
        OFF_CSUM_LO:  ;
        OFF_IDENT_HI: cap.ident[15:8] = data_byte_i;
        OFF_IDENT_LO: cap.ident[7:0]  = data_byte_i;
        OFF_SEQ_HI:   cap.seq[15:8]   = data_byte_i;
        OFF_SEQ_LO:   cap.seq[7:0]    = data_byte_i;
        default:      ;
      endcase
    end

    echo = (cap.icmp_type == ECHO_REPLY_TYPE) && (cap.icmp_code == ECHO_REPLY_CODE);
    pay  = (pos >= {9'd0, hdr_end}) && echo;
    len  = saturated ? MAX_DATAGRAM : pos + 16'd1;
    cap.byte_count = len;

    priority if (len < IP_MIN_LEN) begin
      status = STATUS_SHORT_IP;
    end else if (len < {9'd0, hdr_end}) begin
      status = STATUS_SHORT_ICMP;
    end else if (!echo) begin
      status = STATUS_NOT_ECHO;
    end else begin
      status = STATUS_ACCEPTED;
    end

    nxt_o = last_byte_i ? '0 : cap;

    res_o.payload_valid = pay;
    res_o.payload_byte  = pay ? data_byte_i : 8'd0;
    res_o.done_res      = last_byte_i;
    res_o.status        = last_byte_i ? status : STATUS_ACCEPTED;
    if (last_byte_i && (status == STATUS_ACCEPTED)) begin
      res_o.reply_id       = cap.ident;
      res_o.reply_sequence = cap.seq;
    end else begin
      res_o.reply_id       = 16'd0;
      res_o.reply_sequence = 16'd0;
    end
    res_valid_o = pay || last_byte_i;
  end

endmodule

### rtl/core/icmp_echo_reply_parser.sv
// IPv4 ICMP echo-reply parser. Feed the datagram one byte per request with
// last_byte_i on its final byte; one byte is taken every cycle while the
// output register is free or being read, and its result, if any, is
// registered on the output; the byte counter and captured ICMP header fields
// update combinationally. A result is produced for each echo payload byte and
// for the last byte; the last one carries the verdict and, if accepted, the
// identifier and sequence. Payload bytes of a datagram whose verdict is not
// accepted must be dropped downstream. The ICMP checksum is not checked.
module icmp_echo_reply_parser import ierp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [15:0] reply_id_o,
  output logic [15:0] reply_sequence_o
);

  parse_state_t state_q, state_d;
  result_t      res_q, res_d;
  logic         res_valid_d;
  logic         out_valid_q;
  logic         in_fire;

  ierp_step u_step (
    .cur_i       (state_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .nxt_o       (state_d),
    .res_o       (res_d),
    .res_valid_o (res_valid_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && res_valid_d) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign done_res_o       = res_q.done_res;
  assign status_o         = res_q.status;
  assign reply_id_o       = res_q.reply_id;
  assign reply_sequence_o = res_q.reply_sequence;

endmodule

### verif/icmp_echo_reply_parser_tb.sv
module icmp_echo_reply_parser_tb;
  import ierp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 800000;

  class echo_reply_board;
    result_t     expected_results[$];
    int unsigned mismatches;
    logic [15:0] seen_bytes;
    logic [5:0]  hdr_len;
    logic [7:0]  cap_type;
    logic [7:0]  cap_code;
    logic [15:0] cap_ident;
    logic [15:0] cap_seq;

    function new();
      mismatches = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      seen_bytes = '0;
      hdr_len    = '0;
      cap_type   = '0;
      cap_code   = '0;
      cap_ident  = '0;
      cap_seq    = '0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function string describe(result_t r);
      return $sformatf("pv=%0b byte=%02h done=%0b status=%0d id=%04h seq=%04h",
                       r.payload_valid, r.payload_byte, r.done_res, r.status,
                       r.reply_id, r.reply_sequence);
    endfunction

    // Works out what one accepted request produces and queues it.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned pos;
      int unsigned len;
      int unsigned hdr_end;
      bit          saturated;
      bit          echo;
      bit          pay;
      logic [2:0]  offs;
      result_t     r;
      pos       = seen_bytes;
      saturated = pos >= MAX_DATAGRAM;
      // The first byte of a datagram fixes the header length before any capture.
      if (pos == 0) begin
        cap_type  = '0;
        cap_code  = '0;
        cap_ident = '0;
        cap_seq   = '0;
        hdr_len   = {b[3:0], 2'b00};
      end
      hdr_end = int'(hdr_len) + int'(ICMP_HDR_LEN);
      if (!saturated && pos >= hdr_len && pos < hdr_end) begin
        offs = 3'(pos - hdr_len);
        case (offs)
          OFF_TYPE:     cap_type        = b;
          OFF_CODE:     cap_code        = b;
          OFF_IDENT_HI: cap_ident[15:8] = b;
          OFF_IDENT_LO: cap_ident[7:0]  = b;
          OFF_SEQ_HI:   cap_seq[15:8]   = b;
          OFF_SEQ_LO:   cap_seq[7:0]    = b;
          default: ;
        endcase
      end
      echo = cap_type == ECHO_REPLY_TYPE && cap_code == ECHO_REPLY_CODE;
      pay  = pos >= hdr_end && echo;
      len  = saturated ? int'(MAX_DATAGRAM) : pos + 1;
      seen_bytes = 16'(len);
      if (!pay && !last) return;
      r = '0;
      r.payload_valid = pay;
      if (pay) r.payload_byte = b;
      r.done_res = last;
      if (last) begin
        if (len < IP_MIN_LEN) begin
          r.status = STATUS_SHORT_IP;
        end else if (len < hdr_end) begin
          r.status = STATUS_SHORT_ICMP;
        end else if (!echo) begin
          r.status = STATUS_NOT_ECHO;
        end else begin
          r.status         = STATUS_ACCEPTED;
          r.reply_id       = cap_ident;
          r.reply_sequence = cap_seq;
        end
        clear_datagram();
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected %s", describe(want));
          $display("                 actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic [15:0] reply_id_o;
  logic [15:0] reply_sequence_o;

  echo_reply_board board = new();
  logic [7:0]      frame[$];
  bit              no_idle = 1'b0;
  int unsigned     long_hold = 0;
  int unsigned     bytes_sent = 0;

  icmp_echo_reply_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .reply_id_o       (reply_id_o),
    .reply_sequence_o (reply_sequence_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        got = '{payload_valid_o, payload_byte_o, done_res_o, status_e'(status_o),
                reply_id_o, reply_sequence_o};
        board.check_result(got);
      end
    end
  end

  // Builds a datagram with the ICMP header placed where the length nibble says.
  function automatic void make_frame(logic [3:0] nib, logic [7:0] typ, logic [7:0] code,
                                     logic [15:0] ident, logic [15:0] seq,
                                     int unsigned len);
    int unsigned hdr;
    logic [7:0]  icmp_hdr[8];
    logic [3:0]  version;
    frame.delete();
    repeat (len) frame.push_back(8'($urandom));
    hdr      = nib * 4;
    version  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4;
    icmp_hdr = '{typ, code, 8'($urandom), 8'($urandom),
                 ident[15:8], ident[7:0], seq[15:8], seq[7:0]};
    if (len != 0) frame[0] = {version, nib};
    for (int k = 0; k < 8; k++) begin
      if (hdr + k < len) frame[hdr + k] = icmp_hdr[k];
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned hdr;
    logic [3:0]  nib;
    logic [7:0]  typ;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    nib  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(5, 15)) : 4'($urandom);
    hdr  = nib * 4;
    typ  = ECHO_REPLY_TYPE;
    code = ECHO_REPLY_CODE;
    if ($urandom_range(0, 3) == 0) begin
      typ  = 8'($urandom);
      code = ($urandom_range(0, 1) == 0) ? 8'($urandom) : ECHO_REPLY_CODE;
    end
    if (pick < 70) begin
      make_frame(nib, typ, code, 16'($urandom), 16'($urandom),
                 hdr + 8 + $urandom_range(0, 24));
    end else if (pick < 85) begin
      make_frame(nib, typ, code, 16'($urandom), 16'($urandom),
                 $urandom_range(1, hdr + 8));
    end else begin
      make_frame(nib, typ, code, 16'($urandom), 16'($urandom), $urandom_range(1, 40));
      foreach (frame[i]) frame[i] = 8'($urandom);
    end
    send_frame();
  endtask

  // Receiver: a random stall before each result, or a long hold when asked.
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold != 0) begin
        hold      = long_hold;
        long_hold = 0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin
    int unsigned random_target;
    bit          pressed;
    pressed = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Minimal accepted reply, then field extremes and each verdict.
    make_frame(4'd5, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h0000, 16'h0000, 28);
    send_frame();
    make_frame(4'd5, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'hFFFF, 16'hFFFF, 34);
    send_frame();
    make_frame(4'd5, 8'd8, ECHO_REPLY_CODE, 16'h1234, 16'h5678, 40);
    send_frame();
    make_frame(4'd5, ECHO_REPLY_TYPE, 8'd1, 16'h8001, 16'h7FFE, 36);
    send_frame();
    make_frame(4'd5, 8'hFF, 8'hFF, 16'hAAAA, 16'h5555, 30);
    send_frame();
    make_frame(4'd5, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h0102, 16'h0304, 27);
    send_frame();
    // Short header lengths are used as given, so length 20 decides the verdict.
    make_frame(4'd2, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h0F0F, 16'hF0F0, 19);
    send_frame();
    make_frame(4'd2, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h0F0F, 16'hF0F0, 20);
    send_frame();
    // A zero length nibble puts the ICMP header on the very first byte.
    make_frame(4'd0, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'hBEEF, 16'hCAFE, 24);
    send_frame();
    make_frame(4'd15, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h4242, 16'h2424, 71);
    send_frame();
    make_frame(4'd15, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h4242, 16'h2424, 67);
    send_frame();
    make_frame(4'd5, ECHO_REPLY_TYPE, ECHO_REPLY_CODE, 16'h0000, 16'h0000, 1);
    send_frame();
    drain();

    random_target = bytes_sent + 100;
    while (bytes_sent < random_target) begin
      if (!pressed && bytes_sent + 50 > random_target) begin
        // Hold the output off while requests keep coming, so the input stalls.
        pressed   = 1'b1;
        long_hold = 400;
        no_idle   = 1'b1;
        repeat (2) begin
          make_frame(4'd5, ECHO_REPLY_TYPE, ECHO_REPLY_CODE,
                     16'($urandom), 16'($urandom), 48);
          send_frame();
        end
        no_idle = 1'b0;
        drain();
      end
      no_idle = $urandom_range(0, 9) == 0;
      send_random_frame();
    end
    no_idle = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
